>>> hw/rtl/ksd_pkg.sv
// Package for the keypad scanner: result type, key characters and key lookup.
`timescale 1ns / 1ps

package ksd_pkg;

    localparam int unsigned CountWidth = 18;
    localparam int unsigned ThrWidth   = 16;

    localparam logic signed [CountWidth-1:0] COUNT_MAX = 18'sd131071;
    localparam logic signed [CountWidth-1:0] COUNT_MIN = -18'sd131072;

    localparam logic [ThrWidth-1:0] THRESHOLD_RESET = 16'd100;

    localparam logic [7:0] CHAR_NONE  = 8'h6E; // 'n'
    localparam logic [7:0] CHAR_ERR   = 8'h45; // 'E'
    localparam logic [7:0] CHAR_1     = 8'h31;
    localparam logic [7:0] CHAR_2     = 8'h32;
    localparam logic [7:0] CHAR_3     = 8'h33;
    localparam logic [7:0] CHAR_4     = 8'h34;
    localparam logic [7:0] CHAR_5     = 8'h35;
    localparam logic [7:0] CHAR_6     = 8'h36;
    localparam logic [7:0] CHAR_7     = 8'h37;
    localparam logic [7:0] CHAR_8     = 8'h38;
    localparam logic [7:0] CHAR_9     = 8'h39;
    localparam logic [7:0] CHAR_0     = 8'h30;
    localparam logic [7:0] CHAR_STAR  = 8'h2A;
    localparam logic [7:0] CHAR_HASH  = 8'h23;

    localparam logic [2:0] COLS_IDLE = 3'b111;

    // config register index, taken from paddr[2]
    localparam logic REG_THRESHOLD = 1'b0;

    typedef struct packed {
        logic       key_valid;
        logic [7:0] key_code;
    } ksd_result_t;

    // col and row are zero-based; row_any low means no row was low
    function automatic logic [7:0] key_lookup(input logic [1:0] col, input logic [1:0] row,
                                              input logic row_any);
        logic [7:0] ch;
        ch = CHAR_ERR;
        if (row_any) begin
            case ({col, row})
                4'b00_00: ch = CHAR_1;
                4'b00_01: ch = CHAR_4;
                4'b00_10: ch = CHAR_7;
                4'b00_11: ch = CHAR_STAR;
                4'b01_00: ch = CHAR_2;
                4'b01_01: ch = CHAR_5;
                4'b01_10: ch = CHAR_8;
                4'b01_11: ch = CHAR_0;
                4'b10_00: ch = CHAR_3;
                4'b10_01: ch = CHAR_6;
                4'b10_10: ch = CHAR_9;
                4'b10_11: ch = CHAR_HASH;
                default:  ch = CHAR_ERR;
            endcase
        end
        return ch;
    endfunction

endpackage

>>> hw/rtl/keypad_scan_debounce.sv
// Top level: config register port, debounce core and output register.
// Latency: a result is valid in the cycle after its poll is transferred in.
// Throughput: one poll per cycle while results are taken; the output register
// lets a new poll enter in the same cycle as the waiting result is taken.
// Reset (rst_n low, async): count 0, unlocked, threshold 100, no result held.
`timescale 1ns / 1ps

module keypad_scan_debounce (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  column_levels,
    input  logic [3:0]  row_levels,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        key_valid,
    output logic [7:0]  key_code
);
    import ksd_pkg::*;

    logic [ThrWidth-1:0] threshold_reg;
    logic                out_valid_reg;
    ksd_result_t         result_reg;
    ksd_result_t         core_result;
    logic                accept;
    logic                cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_THRESHOLD);
    assign prdata    = (paddr[2] == REG_THRESHOLD) ? {16'd0, threshold_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            threshold_reg <= THRESHOLD_RESET;
        else if (cfg_write)
            threshold_reg <= pwdata[ThrWidth-1:0];
    end

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    ksd_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .column_levels (column_levels),
        .row_levels    (row_levels),
        .threshold     (threshold_reg),
        .result        (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_ready)
            out_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            result_reg <= core_result;
    end

    assign out_valid = out_valid_reg;
    assign key_valid = result_reg.key_valid;
    assign key_code  = result_reg.key_code;

endmodule

>>> hw/rtl/ksd_core.sv
// Debounce state (count and lock flag) and the per-poll key decision.
`timescale 1ns / 1ps

module ksd_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           accept,
    input  logic [2:0]                     column_levels,
    input  logic [3:0]                     row_levels,
    input  logic [ksd_pkg::ThrWidth-1:0]   threshold,
    output ksd_pkg::ksd_result_t           result
);
    import ksd_pkg::*;

    logic signed [CountWidth-1:0] press_count_reg, press_count_next;
    logic                         locked_reg, locked_next;

    logic       col_any;
    logic [1:0] col_idx;
    logic       row_any;
    logic [1:0] row_idx;

    always_comb
    begin
        col_any = 1'b1;
        col_idx = 2'd0;
        if (!column_levels[0])      col_idx = 2'd0;
        else if (!column_levels[1]) col_idx = 2'd1;
        else if (!column_levels[2]) col_idx = 2'd2;
        else                        col_any = 1'b0;

        row_any = 1'b1;
        row_idx = 2'd0;
        if (!row_levels[0])      row_idx = 2'd0;
        else if (!row_levels[1]) row_idx = 2'd1;
        else if (!row_levels[2]) row_idx = 2'd2;
        else if (!row_levels[3]) row_idx = 2'd3;
        else                     row_any = 1'b0;
    end

    always_comb
    begin
        press_count_next = press_count_reg;
        locked_next      = locked_reg;
        result.key_valid = 1'b0;
        result.key_code  = CHAR_NONE;
        if (!locked_reg) begin
            if (col_any) begin
                if (press_count_reg < COUNT_MAX)
                    press_count_next = press_count_reg + 18'sd1;
                // threshold is unsigned: compare against it zero-extended
                if (press_count_next > $signed({2'b00, threshold})) begin
                    locked_next      = 1'b1;
                    result.key_valid = 1'b1;
                    result.key_code  = key_lookup(col_idx, row_idx, row_any);
                end
            end
        end else begin
            if (column_levels == COLS_IDLE && press_count_reg > COUNT_MIN)
                press_count_next = press_count_reg - 18'sd1;
            // unlock test runs on every locked poll, on the updated count
            if (press_count_next < 0)
                locked_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            press_count_reg <= '0;
            locked_reg      <= 1'b0;
        end else if (accept) begin
            press_count_reg <= press_count_next;
            locked_reg      <= locked_next;
        end
    end

    // count never drops below -1: unlocking happens on the first negative value
    a_count_floor: assert property (@(posedge clk) disable iff (!rst_n)
        press_count_reg >= -18'sd1)
        else $error("press count below -1");

    a_no_key_when_locked: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && locked_reg) |-> !result.key_valid)
        else $error("key registered while locked");

    a_lock_after_key: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && result.key_valid) |=> locked_reg)
        else $error("lock not set after key registration");

endmodule

>>> bench/tb_top.sv
// Testbench for the keypad scanner: directed and random polls checked against a local predictor.
`timescale 1ns / 1ps

module tb_top;
    import ksd_pkg::*;

    localparam logic [2:0] THR_ADDR = {REG_THRESHOLD, 2'b00};
    localparam int unsigned MAX_THR = 65535;
    localparam int unsigned MAX_REPORTS = 50;

    // [column][row], phone layout
    localparam logic [2:0][3:0][7:0] KEY_GRID = {
        {CHAR_HASH, CHAR_9, CHAR_6, CHAR_3},
        {CHAR_0,    CHAR_8, CHAR_5, CHAR_2},
        {CHAR_STAR, CHAR_7, CHAR_4, CHAR_1}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [2:0]  column_levels = COLS_IDLE;
    logic [3:0]  row_levels = 4'hF;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        key_valid;
    logic [7:0]  key_code;

    // predictor state
    logic signed [CountWidth-1:0] press_cnt = '0;
    logic                         key_locked = 1'b0;
    logic [ThrWidth-1:0]          thr_q = THRESHOLD_RESET;
    ksd_result_t                  key_results[$];

    int unsigned error_count = 0;
    logic        quiet = 1'b0;
    int unsigned sink_run = 0;

    keypad_scan_debounce DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .column_levels (column_levels),
        .row_levels    (row_levels),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .key_valid     (key_valid),
        .key_code      (key_code)
    );

    always #4 clk = ~clk;

    initial
    begin
        #10_000_000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic ksd_result_t scan_poll(input logic [2:0] cols, input logic [3:0] rows);
        ksd_result_t res;
        int col;
        int row;
        int i;
        res.key_valid = 1'b0;
        res.key_code = CHAR_NONE;
        col = -1;
        row = -1;
        for (i = 2; i >= 0; i--)
            if (!cols[i])
                col = i;
        if (!key_locked)
        begin
            if (col >= 0)
            begin
                if (press_cnt < COUNT_MAX)
                    press_cnt = press_cnt + 18'sd1;
                if (press_cnt > $signed({2'b00, thr_q}))
                begin
                    key_locked = 1'b1;
                    for (i = 3; i >= 0; i--)
                        if (!rows[i])
                            row = i;
                    res.key_valid = 1'b1;
                    res.key_code = (row >= 0) ? KEY_GRID[col][row] : CHAR_ERR;
                end
            end
        end
        else
        begin
            // count held while any column is low; unlock test runs every locked poll
            if (cols == COLS_IDLE && press_cnt > COUNT_MIN)
                press_cnt = press_cnt - 18'sd1;
            if (press_cnt < 0)
                key_locked = 1'b0;
        end
        return res;
    endfunction

    // random levels with the first low bit at idx
    function automatic logic [3:0] low_at(input int idx);
        logic [3:0] v;
        int i;
        v = 4'($urandom);
        v[idx] = 1'b0;
        for (i = 0; i < idx; i++)
            v[i] = 1'b1;
        return v;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic note_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("%0t: %s mismatch: expected %h, actual %h", $time, what, want, got);
    endtask

    // predict on each input transfer, track register writes
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (psel && penable && pwrite && pready && paddr == THR_ADDR)
                thr_q = pwdata[ThrWidth-1:0];
            if (in_valid && in_ready)
                key_results.push_back(scan_poll(column_levels, row_levels));
        end
    end

    always @(posedge clk)
    begin
        ksd_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (key_results.size() == 0)
            begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("%0t: result with none expected: expected none, actual %b %h",
                             $time, key_valid, key_code);
            end
            else
            begin
                want = key_results.pop_front();
                if (key_valid !== want.key_valid)
                    note_mismatch("key_valid", 32'(want.key_valid), 32'(key_valid));
                if (key_code !== want.key_code)
                    note_mismatch("key_code", 32'(want.key_code), 32'(key_code));
            end
        end
    end

    // receiver stalls: ready runs and gaps of random length
    always @(posedge clk)
    begin
        if (quiet)
        begin
            out_ready <= 1'b1;
            sink_run <= 0;
        end
        else if (sink_run != 0)
        begin
            sink_run <= sink_run - 1;
        end
        else if (!out_ready)
        begin
            out_ready <= 1'b1;
            sink_run <= $urandom_range(0, 40);
        end
        else
        begin
            out_ready <= 1'b0;
            sink_run <= pick_gap();
        end
    end

    task automatic send_poll(input logic [2:0] cols, input logic [3:0] rows);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        column_levels <= cols;
        row_levels <= rows;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic wait_results_done();
        in_valid <= 1'b0;
        @(posedge clk);
        while (key_results.size() != 0) @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic check_thr_readback();
        psel <= 1'b1;
        pwrite <= 1'b0;
        penable <= 1'b0;
        paddr <= THR_ADDR;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        if (prdata !== {16'h0000, thr_q})
            note_mismatch("threshold readback", {16'h0000, thr_q}, prdata);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_threshold(input logic [ThrWidth-1:0] value);
        wait_results_done();
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= THR_ADDR;
        pwdata <= {16'h0000, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        check_thr_readback();
    endtask

    task automatic test_reset_threshold();
        logic [3:0] pat;
        check_thr_readback();
        // threshold 100 out of reset: the 101st press registers
        repeat (101)
        begin
            pat = low_at($urandom_range(0, 2));
            send_poll(pat[2:0], 4'($urandom));
        end
        send_poll(3'($urandom_range(0, 6)), 4'($urandom));
        repeat (102) send_poll(COLS_IDLE, 4'($urandom));
    endtask

    task automatic test_key_map();
        logic [3:0] cpat;
        logic [3:0] rpat;
        int c;
        int r;
        set_threshold(16'd0);
        for (c = 0; c < 3; c++)
        begin
            for (r = 0; r <= 4; r++)
            begin
                cpat = low_at(c);
                rpat = (r == 4) ? 4'hF : low_at(r);
                // count restarts at -1 after unlock, so two presses
                send_poll(cpat[2:0], rpat);
                send_poll(cpat[2:0], rpat);
                send_poll(COLS_IDLE, 4'($urandom));
                send_poll(COLS_IDLE, 4'($urandom));
            end
        end
    endtask

    task automatic test_locked_hold();
        set_threshold(16'd2);
        repeat (4) send_poll(3'b011, 4'($urandom));
        send_poll(3'($urandom_range(0, 6)), 4'($urandom));
        send_poll(COLS_IDLE, 4'($urandom));
        send_poll(3'($urandom_range(0, 6)), 4'($urandom));
        repeat (2) send_poll(COLS_IDLE, 4'($urandom));
        // count at zero: still locked while held
        send_poll(3'($urandom_range(0, 6)), 4'($urandom));
        send_poll(COLS_IDLE, 4'($urandom));
        send_poll(COLS_IDLE, 4'($urandom));
        send_poll(3'b110, 4'($urandom));
    endtask

    task automatic test_threshold_change();
        set_threshold(16'(MAX_THR));
        repeat (20) send_poll(3'b101, 4'($urandom));
        // lowered below the running count: next press registers
        set_threshold(16'd5);
        send_poll(3'b101, 4'($urandom));
        set_threshold(16'd0);
        repeat (24) send_poll(COLS_IDLE, 4'($urandom));
        set_threshold(16'd30);
        repeat (10) send_poll(3'b110, 4'($urandom));
        set_threshold(16'd12);
        repeat (4) send_poll(3'b110, 4'($urandom));
        repeat (16) send_poll(COLS_IDLE, 4'($urandom));
    endtask

    // top threshold with back-to-back polls and the receiver always ready
    task automatic test_max_threshold();
        quiet = 1'b1;
        set_threshold(16'(MAX_THR));
        repeat (40) send_poll(3'($urandom_range(0, 6)), 4'($urandom));
        repeat (8) send_poll(COLS_IDLE, 4'($urandom));
        wait_results_done();
        quiet = 1'b0;
    endtask

    task automatic test_random_keys();
        int unsigned counted;
        int unsigned phase_items;
        int unsigned press_len;
        int unsigned rel_len;
        int unsigned thr_pick;
        logic [2:0] key_cols;
        logic [2:0] cols;
        counted = 0;
        while (counted < 240)
        begin
            case ($urandom_range(0, 5))
                0: thr_pick = 0;
                1: thr_pick = $urandom_range(24, 40);
                default: thr_pick = $urandom_range(1, 6);
            endcase
            set_threshold(16'(thr_pick));
            phase_items = 0;
            while (phase_items < 120)
            begin
                if ($urandom_range(0, 9) < 8)
                begin
                    // press with occasional bounce, then release with occasional re-press
                    key_cols = 3'($urandom_range(0, 6));
                    press_len = thr_pick + $urandom_range(0, 4);
                    repeat (press_len)
                    begin
                        cols = ($urandom_range(0, 9) == 0) ? 3'($urandom) : key_cols;
                        send_poll(cols, 4'($urandom));
                        if (cols != COLS_IDLE)
                            phase_items++;
                    end
                    rel_len = $urandom_range(0, thr_pick + 5);
                    repeat (rel_len)
                    begin
                        cols = ($urandom_range(0, 5) == 0) ? 3'($urandom) : COLS_IDLE;
                        send_poll(cols, 4'($urandom));
                        phase_items++;
                    end
                end
                else
                begin
                    repeat ($urandom_range(1, 8))
                    begin
                        cols = 3'($urandom);
                        send_poll(cols, 4'($urandom));
                        if (cols != COLS_IDLE)
                            phase_items++;
                    end
                end
            end
            counted += phase_items;
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_threshold();
        test_key_map();
        test_locked_hold();
        test_threshold_change();
        test_max_threshold();
        test_random_keys();
        wait_results_done();
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/ksd_pkg.sv
hw/rtl/ksd_core.sv
hw/rtl/keypad_scan_debounce.sv
bench/tb_top.sv
